FILE: rtl/core/cpfd_pkg.sv
// shared constants, types and handshake structs for the cell pair face deduplicator
package cpfd_pkg;

    localparam int DEF_MAX_FACES  = 1024;
    localparam int DEF_HASH_SLOTS = 2048;
    localparam int DEF_CELL_BITS  = 16;

    localparam int DIGIT_BITS     = 16;
    localparam int HASH_BITS      = 64;
    localparam int HASH_HI_BITS   = 32;
    localparam int MOD_STEP_BITS  = 5;
    localparam int EPOCH_BITS     = 8;
    localparam int FACE_OUT_BITS  = 10;
    localparam int CELL_OUT_BITS  = 16;

    localparam logic [HASH_BITS-1:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

    typedef enum logic [2:0] {
        T_CLEAR,
        T_IDLE,
        T_MOD,
        T_PROBE,
        T_CHECK,
        T_DONE
    } tbl_state_t;

    typedef struct packed {
        logic                      start;
        logic                      first_face;
        logic [CELL_OUT_BITS-1:0]  face_cell;
        logic [HASH_HI_BITS-1:0]   hash_hi;
    } cpfd_req_t;

    typedef struct packed {
        logic [FACE_OUT_BITS-1:0]  coarse_face;
        logic                      is_new;
        logic [CELL_OUT_BITS-1:0]  face_cell;
        logic                      overflow;
    } cpfd_res_t;

    typedef struct packed {
        logic idle;
        logic done;
    } cpfd_stat_t;

endpackage

FILE: rtl/core/cpfd_hash_cell.sv
// one cell of the hash multiplier chain: adds one key digit times the hash constant
module cpfd_hash_cell #(
    parameter int INDEX    = 0,
    parameter int KEY_PAD  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [KEY_PAD-1:0]                in_key,
    input  logic [cpfd_pkg::HASH_BITS-1:0]    in_acc,
    output logic                              out_valid,
    output logic [KEY_PAD-1:0]                out_key,
    output logic [cpfd_pkg::HASH_BITS-1:0]    out_acc
);
    import cpfd_pkg::*;

    localparam int SHIFT     = DIGIT_BITS * INDEX;
    localparam int PROD_BITS = DIGIT_BITS + HASH_BITS;

    logic                     valid_reg;
    logic [KEY_PAD-1:0]       key_reg;
    logic [HASH_BITS-1:0]     acc_reg;
    logic [HASH_BITS-1:0]     acc_next;
    logic [DIGIT_BITS-1:0]    digit;
    logic [PROD_BITS-1:0]     prod_full;
    logic [HASH_BITS-1:0]     prod_shifted;

    assign digit        = in_key[SHIFT +: DIGIT_BITS];
    assign prod_full    = PROD_BITS'(digit) * PROD_BITS'(HASH_MULT);
    // only the low 64 bits of the whole product matter
    assign prod_shifted = prod_full[HASH_BITS-1:0] << SHIFT;
    assign acc_next     = in_acc + prod_shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= in_key;
        acc_reg <= acc_next;
    end

    assign out_valid = valid_reg;
    assign out_key   = key_reg;
    assign out_acc   = acc_reg;

endmodule

FILE: rtl/core/cpfd_probe_table.sv
// hashed slot memory with epoch-tagged entries, home slot reduction and linear probe
module cpfd_probe_table #(
    parameter int MAX_FACES  = cpfd_pkg::DEF_MAX_FACES,
    parameter int HASH_SLOTS = cpfd_pkg::DEF_HASH_SLOTS,
    parameter int KEY_BITS   = 2 * cpfd_pkg::DEF_CELL_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cpfd_pkg::cpfd_req_t    req,
    input  logic [KEY_BITS-1:0]    key,
    input  logic                   take,
    output cpfd_pkg::cpfd_stat_t   stat,
    output cpfd_pkg::cpfd_res_t    res
);
    import cpfd_pkg::*;

    localparam int SLOT_BITS  = $clog2(HASH_SLOTS);
    localparam int FC_BITS    = $clog2(MAX_FACES + 1);
    localparam int FACE_BITS  = $clog2(MAX_FACES);
    localparam int ENTRY_BITS = EPOCH_BITS + KEY_BITS + FACE_BITS;
    localparam bit SLOTS_POW2 = (HASH_SLOTS & (HASH_SLOTS - 1)) == 0;

    localparam logic [SLOT_BITS-1:0]     SLOT_LAST   = SLOT_BITS'(HASH_SLOTS - 1);
    localparam logic [SLOT_BITS:0]       SLOT_COUNT  = (SLOT_BITS + 1)'(HASH_SLOTS);
    localparam logic [FC_BITS-1:0]       FACE_LIMIT  = FC_BITS'(MAX_FACES);
    localparam logic [EPOCH_BITS-1:0]    EPOCH_LAST  = {EPOCH_BITS{1'b1}};
    localparam logic [EPOCH_BITS-1:0]    EPOCH_FIRST = EPOCH_BITS'(1);
    localparam logic [MOD_STEP_BITS-1:0] STEP_LAST   = MOD_STEP_BITS'(2);
    localparam logic [HASH_HI_BITS-1:0]  MOD_RECIP   =
        HASH_HI_BITS'((64'd1 << HASH_HI_BITS) / HASH_SLOTS);

    // control state
    tbl_state_t                 state_reg, state_next;
    logic [SLOT_BITS-1:0]       clr_reg, clr_next;
    logic                       pend_reg, pend_next;
    logic [EPOCH_BITS-1:0]      epoch_reg, epoch_next;
    logic [FC_BITS-1:0]         face_count_reg, face_count_next;

    // per-item working registers
    logic [SLOT_BITS-1:0]       slot_reg, slot_next;
    logic [SLOT_BITS-1:0]       visit_reg, visit_next;
    logic [SLOT_BITS:0]         rem_reg, rem_next;
    logic [MOD_STEP_BITS-1:0]   step_reg, step_next;
    logic [HASH_HI_BITS-1:0]    hash_reg, hash_next;
    logic [HASH_HI_BITS-1:0]    quot_reg, quot_next;
    logic [KEY_BITS-1:0]        key_reg, key_next;
    logic [CELL_OUT_BITS-1:0]   face_cell_reg, face_cell_next;
    cpfd_res_t                  res_reg, res_next;

    // slot memory
    logic [ENTRY_BITS-1:0]      slot_mem [HASH_SLOTS];
    logic [ENTRY_BITS-1:0]      rd_data_reg;
    logic                       wr_en;
    logic [SLOT_BITS-1:0]       wr_addr;
    logic [ENTRY_BITS-1:0]      wr_data;
    logic                       rd_en;
    logic [SLOT_BITS-1:0]       rd_addr;

    // decode of the slot under test
    logic [EPOCH_BITS-1:0]      rd_epoch;
    logic [KEY_BITS-1:0]        rd_key;
    logic [FACE_BITS-1:0]       rd_face;
    logic                       slot_free;
    logic                       key_hit;
    logic                       room;
    logic                       probe_end;
    logic [SLOT_BITS-1:0]       slot_inc;
    logic [2*HASH_HI_BITS-1:0]  recip_prod;
    logic [HASH_HI_BITS-1:0]    quot_back;
    logic [HASH_HI_BITS-1:0]    rem_wide;
    logic [SLOT_BITS:0]         rem_step;
    logic                       mod_done;
    logic [SLOT_BITS-1:0]       mod_slot;
    logic [FACE_BITS-1:0]       new_face;
    logic [FACE_BITS+FACE_OUT_BITS-1:0] found_wide;
    logic [FACE_BITS+FACE_OUT_BITS-1:0] new_wide;
    logic                       do_insert;

    assign rd_epoch  = rd_data_reg[ENTRY_BITS-1 -: EPOCH_BITS];
    assign rd_key    = rd_data_reg[FACE_BITS +: KEY_BITS];
    assign rd_face   = rd_data_reg[FACE_BITS-1:0];
    // an entry tagged with an older epoch counts as empty
    assign slot_free = rd_epoch != epoch_reg;
    assign key_hit   = !slot_free && (rd_key == key_reg);
    assign room      = face_count_reg < FACE_LIMIT;
    assign probe_end = slot_free || key_hit || (visit_reg == SLOT_LAST);
    assign slot_inc  = (slot_reg == SLOT_LAST) ? '0 : slot_reg + SLOT_BITS'(1);
    assign do_insert = (state_reg == T_CHECK) && slot_free && room;

    // reciprocal estimate of the quotient, low by at most one, then one correction
    assign recip_prod = (2*HASH_HI_BITS)'(hash_reg) * (2*HASH_HI_BITS)'(MOD_RECIP);
    assign quot_back  = quot_reg * HASH_HI_BITS'(HASH_SLOTS);
    assign rem_wide   = hash_reg - quot_back;
    assign rem_step   = (rem_reg >= SLOT_COUNT) ? rem_reg - SLOT_COUNT : rem_reg;
    assign mod_done   = SLOTS_POW2 || (step_reg == STEP_LAST);
    assign mod_slot   = SLOTS_POW2 ? hash_reg[SLOT_BITS-1:0] : rem_step[SLOT_BITS-1:0];

    assign new_face   = face_count_reg[FACE_BITS-1:0];
    assign found_wide = {FACE_OUT_BITS'(0), rd_face};
    assign new_wide   = {FACE_OUT_BITS'(0), new_face};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_CLEAR:
            begin
                if (clr_reg == SLOT_LAST)
                begin
                    state_next = pend_reg ? T_MOD : T_IDLE;
                end
            end
            T_IDLE:
            begin
                if (req.start)
                begin
                    if (req.first_face && (epoch_reg == EPOCH_LAST))
                    begin
                        state_next = T_CLEAR;
                    end
                    else
                    begin
                        state_next = T_MOD;
                    end
                end
            end
            T_MOD:
            begin
                if (mod_done)
                begin
                    state_next = T_PROBE;
                end
            end
            T_PROBE:
            begin
                state_next = T_CHECK;
            end
            T_CHECK:
            begin
                if (probe_end)
                begin
                    state_next = T_DONE;
                end
            end
            T_DONE:
            begin
                if (take)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clr_next        = clr_reg;
        pend_next       = pend_reg;
        epoch_next      = epoch_reg;
        face_count_next = face_count_reg;
        slot_next       = slot_reg;
        visit_next      = visit_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        hash_next       = hash_reg;
        quot_next       = quot_reg;
        key_next        = key_reg;
        face_cell_next  = face_cell_reg;
        res_next        = res_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_data         = {epoch_reg, key_reg, new_face};
        rd_en           = 1'b0;
        rd_addr         = slot_reg;
        case (state_reg)
            T_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                if (clr_reg == SLOT_LAST)
                begin
                    clr_next  = '0;
                    pend_next = 1'b0;
                end
                else
                begin
                    clr_next = clr_reg + SLOT_BITS'(1);
                end
            end
            T_IDLE:
            begin
                if (req.start)
                begin
                    hash_next      = req.hash_hi;
                    key_next       = key;
                    face_cell_next = req.face_cell;
                    rem_next       = '0;
                    step_next      = '0;
                    visit_next     = '0;
                    if (req.first_face)
                    begin
                        face_count_next = '0;
                        // epoch wrap needs a sweep so old tags cannot alias
                        if (epoch_reg == EPOCH_LAST)
                        begin
                            epoch_next = EPOCH_FIRST;
                            pend_next  = 1'b1;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EPOCH_BITS'(1);
                        end
                    end
                end
            end
            T_MOD:
            begin
                step_next = step_reg + MOD_STEP_BITS'(1);
                if (step_reg == MOD_STEP_BITS'(0))
                begin
                    quot_next = recip_prod[2*HASH_HI_BITS-1 -: HASH_HI_BITS];
                end
                if (step_reg == MOD_STEP_BITS'(1))
                begin
                    rem_next = rem_wide[SLOT_BITS:0];
                end
                if (mod_done)
                begin
                    slot_next = mod_slot;
                end
            end
            T_PROBE:
            begin
                rd_en   = 1'b1;
                rd_addr = slot_reg;
            end
            T_CHECK:
            begin
                if (slot_free)
                begin
                    if (room)
                    begin
                        wr_en                = 1'b1;
                        wr_addr              = slot_reg;
                        face_count_next      = face_count_reg + FC_BITS'(1);
                        res_next.coarse_face = new_wide[FACE_OUT_BITS-1:0];
                        res_next.is_new      = 1'b1;
                        res_next.face_cell   = face_cell_reg;
                        res_next.overflow    = 1'b0;
                    end
                    else
                    begin
                        res_next = '{coarse_face: '0, is_new: 1'b0, face_cell: '0,
                                     overflow: 1'b1};
                    end
                end
                else if (key_hit)
                begin
                    res_next.coarse_face = found_wide[FACE_OUT_BITS-1:0];
                    res_next.is_new      = 1'b0;
                    res_next.face_cell   = '0;
                    res_next.overflow    = 1'b0;
                end
                else if (visit_reg == SLOT_LAST)
                begin
                    // every slot taken by other keys
                    res_next = '{coarse_face: '0, is_new: 1'b0, face_cell: '0,
                                 overflow: 1'b1};
                end
                else
                begin
                    slot_next  = slot_inc;
                    visit_next = visit_reg + SLOT_BITS'(1);
                    rd_en      = 1'b1;
                    rd_addr    = slot_inc;
                end
            end
            T_DONE:
            begin
                res_next = res_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_CLEAR;
            clr_reg        <= '0;
            pend_reg       <= 1'b0;
            epoch_reg      <= EPOCH_FIRST;
            face_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            pend_reg       <= pend_next;
            epoch_reg      <= epoch_next;
            face_count_reg <= face_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        visit_reg     <= visit_next;
        rem_reg       <= rem_next;
        step_reg      <= step_next;
        hash_reg      <= hash_next;
        quot_reg      <= quot_next;
        key_reg       <= key_next;
        face_cell_reg <= face_cell_next;
        res_reg       <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign stat.idle = state_reg == T_IDLE;
    assign stat.done = state_reg == T_DONE;
    assign res       = res_reg;

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        face_count_reg <= FACE_LIMIT)
        else $error("face count above limit");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> face_count_reg == $past(face_count_reg) + FC_BITS'(1))
        else $error("insert did not advance face count");

    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_DONE) |-> !(res_reg.is_new && res_reg.overflow))
        else $error("result both new and overflow");

endmodule

FILE: rtl/core/cell_pair_face_deduplicator_unit.sv
// top level: cell pair face deduplicator with hash multiplier cell chain and probe table
//
//   port group   direction  flow control        payload
//   cfg          in         cfg_valid/ready     is_owner
//   in           in         in_valid/in_stall   local_cell, neighbour_cell, first_face
//   out          out        out_valid/out_stall coarse_face, is_new, face_cell, overflow
//
// one face at a time: hash chain of ceil(2*CELL_BITS/16) cells, home slot reduction (low
// hash bits for a power of two slot count, else a reciprocal quotient estimate, remainder
// and a correction), one slot memory read, then a check of each slot probed, then the
// result is handed to the output register; the next face can transfer once the previous
// result has been handed to the output register.
// after reset, and again on every 255th table clear, a sweep writes all HASH_SLOTS
// entries (one per cycle) while in_stall stays high; config writes are taken at any time.
// a result waiting on out_stall does not block the next face from entering.
module cell_pair_face_deduplicator_unit #(
    parameter int MAX_FACES  = cpfd_pkg::DEF_MAX_FACES,
    parameter int HASH_SLOTS = cpfd_pkg::DEF_HASH_SLOTS,
    parameter int CELL_BITS  = cpfd_pkg::DEF_CELL_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 is_owner,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [cpfd_pkg::CELL_OUT_BITS-1:0]   local_cell,
    input  logic [cpfd_pkg::CELL_OUT_BITS-1:0]   neighbour_cell,
    input  logic                                 first_face,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [cpfd_pkg::FACE_OUT_BITS-1:0]   coarse_face,
    output logic                                 is_new,
    output logic [cpfd_pkg::CELL_OUT_BITS-1:0]   face_cell,
    output logic                                 overflow
);
    import cpfd_pkg::*;

    localparam int KEY_BITS  = 2 * CELL_BITS;
    localparam int NUM_CELLS = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int KEY_PAD   = NUM_CELLS * DIGIT_BITS;

    logic                                is_owner_reg;
    logic                                busy_reg, busy_next;
    logic                                first_reg;
    logic [CELL_OUT_BITS-1:0]            face_cell_reg;
    logic                                out_valid_reg, out_valid_next;
    cpfd_res_t                           out_res_reg;

    logic                                in_accept;
    logic                                take;
    logic                                load;
    logic [CELL_BITS+CELL_OUT_BITS-1:0]  local_wide;
    logic [CELL_BITS+CELL_OUT_BITS-1:0]  nbr_wide;
    logic [CELL_BITS-1:0]                cell_l;
    logic [CELL_BITS-1:0]                cell_n;
    logic [CELL_BITS+CELL_OUT_BITS-1:0]  face_cell_wide;
    logic [KEY_BITS-1:0]                 key_in;
    logic [KEY_PAD+KEY_BITS-1:0]         key_wide;

    logic                                link_valid [0:NUM_CELLS];
    logic [KEY_PAD-1:0]                  link_key   [0:NUM_CELLS];
    logic [HASH_BITS-1:0]                link_acc   [0:NUM_CELLS];

    cpfd_req_t                           req;
    cpfd_stat_t                          stat;
    cpfd_res_t                           res;

    assign cfg_ready = 1'b1;

    // mask cells to CELL_BITS, then face_cell back to 16 bits
    assign local_wide     = {CELL_BITS'(0), local_cell};
    assign nbr_wide       = {CELL_BITS'(0), neighbour_cell};
    assign cell_l         = local_wide[CELL_BITS-1:0];
    assign cell_n         = nbr_wide[CELL_BITS-1:0];
    assign face_cell_wide = {CELL_OUT_BITS'(0), cell_l};
    assign key_in         = is_owner_reg ? {cell_l, cell_n} : {cell_n, cell_l};
    assign key_wide       = {KEY_PAD'(0), key_in};

    assign in_stall  = busy_reg || !stat.idle;
    assign in_accept = in_valid && !in_stall;
    assign take      = !out_valid_reg || !out_stall;
    assign load      = stat.done && take;

    assign link_valid[0] = in_accept;
    assign link_key[0]   = key_wide[KEY_PAD-1:0];
    assign link_acc[0]   = '0;

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        cpfd_hash_cell #(
            .INDEX   (k),
            .KEY_PAD (KEY_PAD)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[k]),
            .in_key    (link_key[k]),
            .in_acc    (link_acc[k]),
            .out_valid (link_valid[k+1]),
            .out_key   (link_key[k+1]),
            .out_acc   (link_acc[k+1])
        );
    end

    assign req.start      = link_valid[NUM_CELLS];
    assign req.first_face = first_reg;
    assign req.face_cell  = face_cell_reg;
    assign req.hash_hi    = link_acc[NUM_CELLS][HASH_BITS-1 -: HASH_HI_BITS];

    cpfd_probe_table #(
        .MAX_FACES  (MAX_FACES),
        .HASH_SLOTS (HASH_SLOTS),
        .KEY_BITS   (KEY_BITS)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .key   (link_key[NUM_CELLS][KEY_BITS-1:0]),
        .take  (take),
        .stat  (stat),
        .res   (res)
    );

    assign busy_next      = in_accept ? 1'b1 : (load ? 1'b0 : busy_reg);
    assign out_valid_next = load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_owner_reg  <= 1'b1;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                is_owner_reg <= is_owner;
            end
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            first_reg     <= first_face;
            face_cell_reg <= face_cell_wide[CELL_OUT_BITS-1:0];
        end
        if (load)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign coarse_face = out_res_reg.coarse_face;
    assign is_new      = out_res_reg.is_new;
    assign face_cell   = out_res_reg.face_cell;
    assign overflow    = out_res_reg.overflow;

    a_hash_lands: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[NUM_CELLS] |-> busy_reg && stat.idle)
        else $error("hash arrived while table not ready");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> busy_reg)
        else $error("table result with no face in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(out_res_reg))
        else $error("stalled result changed");

endmodule
